[design/pmct_pkg.sv]
package pmct_pkg;

  // Field and register widths.
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned TICK_W       = 32;
  localparam int unsigned OUT_COORD_W  = 11;
  localparam int unsigned SCREEN_REG_W = 11;
  localparam int unsigned WINDOW_W     = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  // Defaults for the top-level parameters.
  localparam int unsigned EVENT_DEPTH_DEF = 512;
  localparam int unsigned COORD_BITS_DEF  = 11;

  // Depths of the queue between the two halves and of the result queue.
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DCLICK_WINDOW = 2'd2;

  // Register reset values.
  localparam int unsigned SCREEN_W_RST = 320;
  localparam int unsigned SCREEN_H_RST = 200;
  localparam int unsigned WINDOW_RST   = 200;
  localparam logic [TICK_W-1:0] LAST_CLICK_RST = 32'hFFFF_FC18;

  // PS/2 header byte layout.
  localparam int unsigned HDR_BTN_LEFT   = 0;
  localparam int unsigned HDR_BTN_RIGHT  = 1;
  localparam int unsigned HDR_BTN_MIDDLE = 2;
  localparam int unsigned HDR_SYNC_BIT   = 3;
  localparam int unsigned HDR_X_SIGN     = 4;
  localparam int unsigned HDR_Y_SIGN     = 5;
  localparam int unsigned HDR_X_OVF      = 6;
  localparam int unsigned HDR_Y_OVF      = 7;

  localparam logic [BYTE_W-1:0] RESYNC_BYTE = 8'h0C;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_SINGLE = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_RIGHT  = 3'd3,
    EV_MIDDLE = 3'd4
  } ev_type_e;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_PACKET = 2'd1,
    OP_POP    = 2'd2
  } op_e;

  // Work handed from the framing front end to the back end.
  typedef struct packed {
    op_e                op;
    logic [2:0]         buttons;
    logic signed [3:0]  dx;
    logic signed [3:0]  dy;
    logic               moving;
    logic [TICK_W-1:0]  tick;
  } op_item_t;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] cursor_x;
    logic [OUT_COORD_W-1:0] cursor_y;
    logic                   packet_done;
    logic                   event_valid;
    ev_type_e               event_type;
    logic [OUT_COORD_W-1:0] event_x;
    logic [OUT_COORD_W-1:0] event_y;
  } res_t;

endpackage

[design/pmct_fifo.sv]
module pmct_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    if (p == PtrW'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    rd_ptr_d = do_pop ? ptr_next(rd_ptr_q) : rd_ptr_q;
    wr_ptr_d = do_push ? ptr_next(wr_ptr_q) : wr_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[design/pmct_front.sv]
module pmct_front import pmct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              cmd_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  logic [TICK_W-1:0] now_ms_i,
  output op_item_t          item_o
);

  typedef enum logic [2:0] {
    RS_WAIT_ZERO = 3'b001,
    RS_ONE_ZERO  = 3'b010,
    RS_IDLE      = 3'b100
  } rs_state_e;

  rs_state_e         rs_q, rs_d;
  logic [1:0]        byte_idx_q, byte_idx_d;
  logic [BYTE_W-1:0] header_q, header_d;
  logic [8:0]        x_motion_q, x_motion_d;
  logic [TICK_W-1:0] tick_q, tick_d;

  logic [1:0] idx;
  logic       resync_hit;
  logic       complete;
  logic       overflow;
  logic [8:0] y_motion;

  assign y_motion = {header_q[HDR_Y_SIGN], rx_byte_i};
  assign overflow = header_q[HDR_X_OVF] || header_q[HDR_Y_OVF];

  always_comb begin
    rs_d       = rs_q;
    header_d   = header_q;
    x_motion_d = x_motion_q;
    tick_d     = tick_q;
    resync_hit = 1'b0;
    complete   = 1'b0;
    idx        = byte_idx_q + 1'b1;

    // A 0x0C byte followed by two zero bytes restarts framing.
    if (rs_q == RS_WAIT_ZERO && rx_byte_i == '0) begin
      rs_d = RS_ONE_ZERO;
    end else if (rs_q == RS_ONE_ZERO && rx_byte_i == '0) begin
      resync_hit = 1'b1;
      rs_d       = RS_IDLE;
    end else if (rx_byte_i == RESYNC_BYTE) begin
      rs_d = RS_WAIT_ZERO;
    end else begin
      rs_d = RS_IDLE;
    end

    case (idx)
      2'd1: begin
        if (rx_byte_i[HDR_SYNC_BIT]) begin
          header_d = rx_byte_i;
          tick_d   = now_ms_i;
        end else begin
          idx = 2'd0;
        end
      end
      2'd2: begin
        x_motion_d = {header_q[HDR_X_SIGN], rx_byte_i};
      end
      default: ;
    endcase

    if (resync_hit) begin
      idx = 2'd0;
    end else if (idx == 2'd3) begin
      complete = 1'b1;
      idx      = 2'd0;
    end
    byte_idx_d = idx;

    if (cmd_i) begin
      item_o.op = OP_POP;
    end else if (complete && !overflow) begin
      item_o.op = OP_PACKET;
    end else begin
      item_o.op = OP_BYTE;
    end
    item_o.buttons = header_q[2:0];
    // An arithmetic shift by five of a 9-bit value keeps its top four bits.
    item_o.dx      = x_motion_q[8:5];
    item_o.dy      = y_motion[8:5];
    item_o.moving  = (x_motion_q != '0) || (y_motion != '0);
    item_o.tick    = tick_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q       <= RS_WAIT_ZERO;
      byte_idx_q <= '0;
      header_q   <= '0;
      x_motion_q <= '0;
      tick_q     <= '0;
    end else if (accept_i && !cmd_i) begin
      rs_q       <= rs_d;
      byte_idx_q <= byte_idx_d;
      header_q   <= header_d;
      x_motion_q <= x_motion_d;
      tick_q     <= tick_d;
    end
  end

endmodule

[design/pmct_back.sv]
module pmct_back import pmct_pkg::*; #(
  parameter int unsigned EVENT_DEPTH = EVENT_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  op_item_t              item_i,
  input  logic                  item_valid_i,
  output logic                  item_take_o,
  input  logic [OUT_CNT_W-1:0]  out_count_i,
  output logic                  res_valid_o,
  output res_t                  res_o
);

  localparam int unsigned PtrW     = $clog2(EVENT_DEPTH);
  localparam int unsigned CoordMax = (1 << COORD_BITS) - 1;
  localparam int unsigned SumW     = COORD_BITS + 2;
  localparam int unsigned LimW     = 17;
  localparam int unsigned RstX =
    ((SCREEN_W_RST > CoordMax) ? CoordMax : SCREEN_W_RST) / 2;
  localparam int unsigned RstY =
    ((SCREEN_H_RST > CoordMax) ? CoordMax : SCREEN_H_RST) / 2;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    ev_type_e etype;
    coord_t   x;
    coord_t   y;
  } ring_entry_t;

  logic [SCREEN_REG_W-1:0] screen_w_q, screen_h_q;
  logic [WINDOW_W-1:0]     window_q;

  coord_t            pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  coord_t            bef_x_q, bef_x_d, bef_y_q, bef_y_d;
  logic [TICK_W-1:0] last_click_q, last_click_d;
  logic [PtrW-1:0]   rptr_q, rptr_d, wptr_q, wptr_d;

  ring_entry_t ring_q [EVENT_DEPTH];
  ring_entry_t rd_q;
  ring_entry_t wr_entry;
  logic        ring_we, ring_re;

  logic   s2_valid_q, s2_done_q, s2_hit_q;
  coord_t s2_x_q, s2_y_q;
  logic   done;

  coord_t                  wx, hy;
  logic signed [SumW-1:0]  sum_x, sum_y;
  logic [TICK_W-1:0]       since_click;
  logic                    is_double;
  logic [OUT_CNT_W:0]      pending;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] p);
    if (p == PtrW'(EVENT_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic coord_t clamp_c(logic signed [SumW-1:0] v, coord_t hi);
    if (v < 0) begin
      return '0;
    end
    if (v > $signed({2'b00, hi})) begin
      return hi;
    end
    return v[COORD_BITS-1:0];
  endfunction

  // Result-queue credit: count what is queued plus what is still in the read stage.
  assign pending     = {1'b0, out_count_i} + (OUT_CNT_W + 1)'(s2_valid_q);
  assign item_take_o = item_valid_i && (pending < (OUT_CNT_W + 1)'(OUT_DEPTH));

  assign wx = ({{(LimW - SCREEN_REG_W){1'b0}}, screen_w_q} > LimW'(CoordMax))
              ? COORD_BITS'(CoordMax) : COORD_BITS'(screen_w_q);
  assign hy = ({{(LimW - SCREEN_REG_W){1'b0}}, screen_h_q} > LimW'(CoordMax))
              ? COORD_BITS'(CoordMax) : COORD_BITS'(screen_h_q);

  assign sum_x = $signed({2'b00, pos_x_q}) + SumW'(item_i.dx);
  assign sum_y = $signed({2'b00, pos_y_q}) - SumW'(item_i.dy);

  assign since_click = item_i.tick - last_click_q;
  assign is_double   = since_click < {{(TICK_W - WINDOW_W){1'b0}}, window_q};

  always_comb begin
    pos_x_d      = pos_x_q;
    pos_y_d      = pos_y_q;
    bef_x_d      = bef_x_q;
    bef_y_d      = bef_y_q;
    last_click_d = last_click_q;
    rptr_d       = rptr_q;
    wptr_d       = wptr_q;
    ring_we      = 1'b0;
    ring_re      = 1'b0;
    done         = 1'b0;
    wr_entry     = '{etype: EV_MIDDLE, x: bef_x_q, y: bef_y_q};

    if (item_take_o) begin
      case (item_i.op)
        OP_PACKET: begin
          done = 1'b1;
          if (item_i.moving) begin
            bef_x_d = pos_x_q;
            bef_y_d = pos_y_q;
            pos_x_d = clamp_c(sum_x, wx);
            pos_y_d = clamp_c(sum_y, hy);
          end
          wr_entry.x = bef_x_d;
          wr_entry.y = bef_y_d;
          if (item_i.buttons != '0) begin
            // Right wins over left; middle alone gets its own code.
            if (item_i.buttons[HDR_BTN_RIGHT]) begin
              wr_entry.etype = EV_RIGHT;
            end else if (item_i.buttons[HDR_BTN_LEFT]) begin
              wr_entry.etype = is_double ? EV_DOUBLE : EV_SINGLE;
            end else begin
              wr_entry.etype = EV_MIDDLE;
            end
            if (item_i.buttons[HDR_BTN_MIDDLE]) begin
              pos_x_d = wx >> 1;
              pos_y_d = hy >> 1;
            end
            ring_we      = 1'b1;
            wptr_d       = ptr_next(wptr_q);
            last_click_d = item_i.tick;
          end
        end
        OP_POP: begin
          if (rptr_q != wptr_q) begin
            ring_re = 1'b1;
            rptr_d  = ptr_next(rptr_q);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_w_q <= SCREEN_REG_W'(SCREEN_W_RST);
      screen_h_q <= SCREEN_REG_W'(SCREEN_H_RST);
      window_q   <= WINDOW_W'(WINDOW_RST);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SCREEN_WIDTH:  screen_w_q <= cfg_data_i[SCREEN_REG_W-1:0];
        CFG_SCREEN_HEIGHT: screen_h_q <= cfg_data_i[SCREEN_REG_W-1:0];
        CFG_DCLICK_WINDOW: window_q   <= cfg_data_i[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q      <= COORD_BITS'(RstX);
      pos_y_q      <= COORD_BITS'(RstY);
      bef_x_q      <= '0;
      bef_y_q      <= '0;
      last_click_q <= LAST_CLICK_RST;
      rptr_q       <= '0;
      wptr_q       <= '0;
      s2_valid_q   <= 1'b0;
    end else begin
      pos_x_q      <= pos_x_d;
      pos_y_q      <= pos_y_d;
      bef_x_q      <= bef_x_d;
      bef_y_q      <= bef_y_d;
      last_click_q <= last_click_d;
      rptr_q       <= rptr_d;
      wptr_q       <= wptr_d;
      s2_valid_q   <= item_take_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      s2_x_q    <= pos_x_d;
      s2_y_q    <= pos_y_d;
      s2_done_q <= done;
      s2_hit_q  <= ring_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[wptr_q] <= wr_entry;
    end
    if (ring_re) begin
      rd_q <= ring_q[rptr_q];
    end
  end

  assign res_valid_o          = s2_valid_q;
  assign res_o.cursor_x       = OUT_COORD_W'(s2_x_q);
  assign res_o.cursor_y       = OUT_COORD_W'(s2_y_q);
  assign res_o.packet_done    = s2_done_q;
  assign res_o.event_valid    = s2_hit_q;
  assign res_o.event_type     = s2_hit_q ? rd_q.etype : EV_NONE;
  assign res_o.event_x        = s2_hit_q ? OUT_COORD_W'(rd_q.x) : '0;
  assign res_o.event_y        = s2_hit_q ? OUT_COORD_W'(rd_q.y) : '0;

endmodule

[design/ps2_mouse_packet_cursor_tracker_top.sv]
// PS/2 mouse packet decoder with cursor tracking and a click-event ring. Each
// transfer on the input queue is either a mouse byte with its millisecond tick
// or a request to pop the oldest click event, and each gives exactly one result
// on the output queue, in order. One item is taken per clock cycle while the
// middle queue holds one and the result queue has room. The framing front end
// writes the work item into a short queue as it takes it; when the execute
// stage takes the item it updates the cursor and ring pointers while the event
// memory is read into a register, and from that register the result enters the
// result queue. The execute stage carries the cursor position, last click tick
// and ring pointers from one item to the next. Short queues sit between the
// front end and the execute stage and in front of the result ports, so either
// side may stall without stopping the other. The event ring holds EVENT_DEPTH
// entries in a memory with no clearing pass, so the block takes items from the
// first cycle after reset; writes never check for room, so once EVENT_DEPTH
// events are pending unread the ring reads as empty again. Configuration writes
// take effect on the next cycle and are meant for times when no item is in
// flight.
module ps2_mouse_packet_cursor_tracker_top import pmct_pkg::*; #(
  parameter int unsigned EVENT_DEPTH = EVENT_DEPTH_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic                   cmd_i,
  input  logic [BYTE_W-1:0]      rx_byte_i,
  input  logic [TICK_W-1:0]      now_ms_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [OUT_COORD_W-1:0] cursor_x_o,
  output logic [OUT_COORD_W-1:0] cursor_y_o,
  output logic                   packet_done_o,
  output logic                   event_valid_o,
  output logic [2:0]             event_type_o,
  output logic [OUT_COORD_W-1:0] event_x_o,
  output logic [OUT_COORD_W-1:0] event_y_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic                 in_xfer;
  op_item_t             front_item;
  op_item_t             mid_item;
  logic                 mid_empty;
  logic                 mid_take;
  logic [$clog2(MID_DEPTH + 1)-1:0] mid_count;
  logic                 res_valid;
  res_t                 res;
  res_t                 out_res;
  logic                 out_full;
  logic [OUT_CNT_W-1:0] out_count;

  assign in_xfer = push && !full;

  pmct_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_xfer),
    .cmd_i     (cmd_i),
    .rx_byte_i (rx_byte_i),
    .now_ms_i  (now_ms_i),
    .item_o    (front_item)
  );

  pmct_fifo #(
    .WIDTH ($bits(op_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_xfer),
    .data_i  (front_item),
    .pop_i   (mid_take),
    .data_o  (mid_item),
    .empty_o (mid_empty),
    .full_o  (full),
    .count_o (mid_count)
  );

  pmct_back #(
    .EVENT_DEPTH (EVENT_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .item_i       (mid_item),
    .item_valid_i (!mid_empty),
    .item_take_o  (mid_take),
    .out_count_i  (out_count),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  pmct_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty),
    .full_o  (out_full),
    .count_o (out_count)
  );

  assign cursor_x_o    = out_res.cursor_x;
  assign cursor_y_o    = out_res.cursor_y;
  assign packet_done_o = out_res.packet_done;
  assign event_valid_o = out_res.event_valid;
  assign event_type_o  = out_res.event_type;
  assign event_x_o     = out_res.event_x;
  assign event_y_o     = out_res.event_y;

`ifndef SYNTHESIS
  // The execute stage only issues work it has result-queue room for.
  ap_out_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !out_full)
    else $error("result pushed into a full result queue");

  // A byte that completes a packet never also reports a popped event.
  ap_done_excl_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && packet_done_o) |-> !event_valid_o)
    else $error("packet_done and event_valid set together");

  // Results without a popped event carry a cleared event payload.
  ap_no_event_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !event_valid_o) |->
      (event_type_o == EV_NONE && event_x_o == '0 && event_y_o == '0))
    else $error("event payload set without a popped event");

  // The middle queue's empty flag agrees with its fill count.
  ap_mid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_empty == (mid_count == '0))
    else $error("middle queue empty flag disagrees with its count");
`endif

endmodule
